>>> src/pfhu_pkg.sv
// Shared types, codes and stage constants for the forwarding and hazard unit.
package pfhu_pkg;

  localparam int unsigned RegW       = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned NumStages  = 4;
  localparam int unsigned StageDec   = 0;
  localparam int unsigned StageExe   = 1;
  localparam int unsigned StageMem   = 2;
  localparam int unsigned StageWb    = 3;

  localparam logic [RegW-1:0] RegsEmbedded = RegW'(16);

  typedef enum logic [2:0] {
    OP_ADVANCE  = 3'd0,
    OP_SET_DEST = 3'd1,
    OP_POST_EXE = 3'd2,
    OP_POST_MEM = 3'd3,
    OP_QUERY    = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_INVALID    = 3'd1,
    ERR_PENDING    = 3'd2,
    ERR_MISSING    = 3'd3,
    ERR_NOT_FILLED = 3'd4
  } err_e;

  // One pipeline stage entry
  typedef struct packed {
    logic [RegW-1:0]  dest;
    logic [DataW-1:0] value;
    logic             has_value;
    logic             filled;
  } entry_t;

  // Query answer handed along the cell chain
  typedef struct packed {
    logic             stale;
    logic [DataW-1:0] value;
    err_e             err;
  } result_t;

  // Per-cell update strobes
  typedef struct packed {
    logic advance;
    logic post;
    logic set_dest;
  } cell_ctrl_t;

  // Per-stage query behavior
  typedef struct packed {
    logic match_en;
    logic fwd_en;
    logic miss_stale;
    err_e miss_err;
  } cell_cfg_t;

  localparam cell_cfg_t StageCfg [NumStages] = '{
    '{match_en: 1'b0, fwd_en: 1'b0, miss_stale: 1'b0, miss_err: ERR_OK},
    '{match_en: 1'b1, fwd_en: 1'b0, miss_stale: 1'b1, miss_err: ERR_PENDING},
    '{match_en: 1'b1, fwd_en: 1'b1, miss_stale: 1'b1, miss_err: ERR_MISSING},
    '{match_en: 1'b1, fwd_en: 1'b1, miss_stale: 1'b0, miss_err: ERR_MISSING}
  };

endpackage

>>> src/pipeline_forwarding_hazard_unit.sv
// Top level: request decode, chain of four stage cells, registered result.
//
//  channel   | direction | contents
//  s_axis    | in        | tuser: opcode; tdata: dest_reg, query_reg, data_value, file_value
//  m_axis    | out       | tdata: stale, read_value, error_code
//  cfg       | in        | cfg_we_i / cfg_wdata_i: embedded_mode
//
// One request per cycle unless stalled; a result appears in the cycle after its request.
// The cells update at the accepting edge; a query resolves through the cell chain
// in the same cycle, from writeback up to decode.
// The input stalls only while a result is held and m_axis_tready is low.
// Reset clears all stage entries, embedded_mode and the output register.
module pipeline_forwarding_hazard_unit import pfhu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,  // [2:0] opcode
  input  logic [79:0] s_axis_tdata,  // [4:0] dest_reg, [9:5] query_reg,
                                     // [41:10] data_value, [73:42] file_value, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] stale, [32:1] read_value, [35:33] error_code
);

  logic             embedded_q;
  logic             in_fire;
  opcode_e          opcode;
  logic [RegW-1:0]  dest_reg;
  logic [RegW-1:0]  query_reg;
  logic [DataW-1:0] data_value;
  logic [DataW-1:0] file_value;

  entry_t     entry   [NumStages];
  cell_ctrl_t ctrl    [NumStages];
  result_t    chain   [NumStages+1];
  entry_t     fresh;
  result_t    res_d;
  result_t    res_q;
  logic       out_valid_q;

  assign opcode     = opcode_e'(s_axis_tuser);
  assign dest_reg   = s_axis_tdata[4:0];
  assign query_reg  = s_axis_tdata[9:5];
  assign data_value = s_axis_tdata[41:10];
  assign file_value = s_axis_tdata[73:42];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      embedded_q <= 1'b0;
    end else if (cfg_we_i) begin
      embedded_q <= cfg_wdata_i;
    end
  end

  // New decode entry on advance: filled, no destination, no value
  always_comb begin
    fresh        = '0;
    fresh.filled = 1'b1;
  end

  assign chain[NumStages] = '{stale: 1'b0, value: file_value, err: ERR_OK};

  for (genvar i = 0; i < NumStages; i++) begin : g_cell
    assign ctrl[i].advance  = in_fire && (opcode == OP_ADVANCE);
    assign ctrl[i].post     = in_fire &&
                              (((i == StageExe) && (opcode == OP_POST_EXE)) ||
                               ((i == StageMem) && (opcode == OP_POST_MEM)));
    assign ctrl[i].set_dest = in_fire && (i == StageDec) && (opcode == OP_SET_DEST);

    pfhu_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (StageCfg[i]),
      .ctrl_i      (ctrl[i]),
      .prev_i      ((i == 0) ? fresh : entry[(i == 0) ? 0 : i-1]),
      .dest_i      (dest_reg),
      .data_i      (data_value),
      .query_reg_i (query_reg),
      .result_i    (chain[i+1]),
      .entry_o     (entry[i]),
      .result_o    (chain[i])
    );
  end

  always_comb begin
    res_d = '{stale: 1'b0, value: '0, err: ERR_OK};
    case (opcode)
      OP_POST_EXE: begin
        if (!entry[StageExe].filled) res_d.err = ERR_NOT_FILLED;
      end
      OP_POST_MEM: begin
        if (!entry[StageMem].filled) res_d.err = ERR_NOT_FILLED;
      end
      OP_QUERY: begin
        if (embedded_q && (query_reg >= RegsEmbedded)) begin
          res_d.err = ERR_INVALID;
        end else if (query_reg != '0) begin
          res_d = chain[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '{stale: 1'b0, value: '0, err: ERR_OK};
    end else if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q.err, res_q.value, res_q.stale};

endmodule

>>> src/pfhu_cell.sv
// One pipeline stage cell: holds an entry, shifts it on, and resolves its query match.
module pfhu_cell import pfhu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cfg_t        cfg_i,
  input  cell_ctrl_t       ctrl_i,
  input  entry_t           prev_i,
  input  logic [RegW-1:0]  dest_i,
  input  logic [DataW-1:0] data_i,
  input  logic [RegW-1:0]  query_reg_i,
  input  result_t          result_i,
  output entry_t           entry_o,
  output result_t          result_o
);

  entry_t entry_q, entry_d;
  logic   hit;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.advance) begin
      entry_d = prev_i;
    end else begin
      if (ctrl_i.post && entry_q.filled) begin
        entry_d.value     = data_i;
        entry_d.has_value = 1'b1;
      end
      if (ctrl_i.set_dest) begin
        entry_d.dest = dest_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  // Later stages feed in first; a hit here overrides their answer.
  assign hit = cfg_i.match_en && entry_q.filled && (entry_q.dest == query_reg_i);

  always_comb begin
    result_o = result_i;
    if (hit) begin
      if (cfg_i.fwd_en && entry_q.has_value) begin
        result_o.stale = 1'b0;
        result_o.value = entry_q.value;
        result_o.err   = ERR_OK;
      end else begin
        result_o.stale = cfg_i.miss_stale;
        result_o.value = '0;
        result_o.err   = cfg_i.miss_err;
      end
    end
  end

  assign entry_o = entry_q;

endmodule

>>> sim/tb.sv
// Testbench for the forwarding and hazard unit: stream stimulus, in-bench prediction, checks.
`timescale 1ns / 100ps

module tb;
  import pfhu_pkg::*;

  // Opcodes 5 to 7 are not decoded; this is the top one
  localparam logic [2:0] OpReserved = 3'd7;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]       op;
    logic [RegW-1:0]  dest;
    logic [RegW-1:0]  qreg;
    logic [DataW-1:0] data;
    logic [DataW-1:0] fval;
  } request_t;

  typedef struct packed {
    logic             stale;
    logic [DataW-1:0] value;
    logic [2:0]       err;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;   // [2:0] opcode
  logic [79:0] s_axis_tdata = '0;   // [4:0] dest_reg, [9:5] query_reg,
                                    // [41:10] data_value, [73:42] file_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [0] stale, [32:1] read_value, [35:33] error_code

  pipeline_forwarding_hazard_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  request_t request_q[$];
  answer_t  answer_q[$];
  request_t cur_req;
  bit       req_taken = 1'b0;
  int       src_idle_pct = 37;
  int       sink_idle_pct = 37;
  bit       hold_off_req = 1'b0;
  int       hold_left = 0;
  int       errors = 0;

  // Shadow copy of the pipeline entries and the mode bit
  logic             embedded_mode = 1'b0;
  logic [RegW-1:0]  st_dest   [NumStages] = '{default: '0};
  logic [DataW-1:0] st_value  [NumStages] = '{default: '0};
  logic             st_has    [NumStages] = '{default: 1'b0};
  logic             st_filled [NumStages] = '{default: 1'b0};

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    a = '0;
    case (r.op)
      OP_ADVANCE: begin
        for (int i = NumStages - 1; i > 0; i--) begin
          st_dest[i]   = st_dest[i-1];
          st_value[i]  = st_value[i-1];
          st_has[i]    = st_has[i-1];
          st_filled[i] = st_filled[i-1];
        end
        st_dest[StageDec]   = '0;
        st_value[StageDec]  = '0;
        st_has[StageDec]    = 1'b0;
        st_filled[StageDec] = 1'b1;
      end
      OP_SET_DEST: st_dest[StageDec] = r.dest;
      OP_POST_EXE, OP_POST_MEM: begin
        int st;
        st = (r.op == OP_POST_EXE) ? StageExe : StageMem;
        if (!st_filled[st]) begin
          a.err = ERR_NOT_FILLED;
        end else begin
          st_value[st] = r.data;
          st_has[st]   = 1'b1;
        end
      end
      OP_QUERY: begin
        if (embedded_mode && r.qreg >= RegsEmbedded) begin
          a.err = ERR_INVALID;
        end else if (r.qreg == '0) begin
          // x0 reads as zero
        end else if (st_filled[StageExe] && st_dest[StageExe] == r.qreg) begin
          a.stale = 1'b1;
          a.err   = ERR_PENDING;
        end else if (st_filled[StageMem] && st_dest[StageMem] == r.qreg) begin
          if (st_has[StageMem]) begin
            a.value = st_value[StageMem];
          end else begin
            a.stale = 1'b1;
            a.err   = ERR_MISSING;
          end
        end else if (st_filled[StageWb] && st_dest[StageWb] == r.qreg) begin
          if (st_has[StageWb]) a.value = st_value[StageWb];
          else a.err = ERR_MISSING;
        end else begin
          a.value = r.fval;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Monitor and scoreboard: sample at the rising edge
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{stale: m_axis_tdata[0], value: m_axis_tdata[32:1], err: m_axis_tdata[35:33]};
        if (answer_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (got.stale !== want.stale) begin
            $error("stale: expected %0d, got %0d", want.stale, got.stale);
            errors++;
          end
          if (got.value !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, got.value);
            errors++;
          end
          if (got.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, got.err);
            errors++;
          end
        end
      end
      if (cfg_we_i) embedded_mode = cfg_wdata_i;
      req_taken = s_axis_tvalid && s_axis_tready;
      if (req_taken) answer_q.insert(answer_q.size(), apply_request(cur_req));
    end
  end

  // Request driver: holds a request until taken, then moves on or idles
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !req_taken)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_req = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_req.op;
        s_axis_tdata  <= {6'b0, cur_req.fval, cur_req.data, cur_req.qreg, cur_req.dest};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with random backpressure and an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_left = 120;
      hold_off_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic push_req(logic [2:0] op, logic [4:0] dest, logic [4:0] qreg,
                          logic [31:0] data, logic [31:0] fval);
    request_q.insert(request_q.size(),
                     '{op: op, dest: dest, qreg: qreg, data: data, fval: fval});
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return AllOnes;
      default: return $urandom;
    endcase
  endfunction

  // Checked at the rising edge, where the driver's outputs have settled
  task automatic wait_drained();
    do @(posedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly instruction-shaped slots: set dest, queries, posts, advance; some noise
  task automatic queue_program(int n_items);
    logic [4:0] recent [4];
    logic [4:0] q;
    int pushed;
    pushed = 0;
    foreach (recent[i]) recent[i] = 5'($urandom_range(31));
    while (pushed < n_items) begin
      if ($urandom_range(99) < 12) begin
        push_req(3'($urandom_range(7)), 5'($urandom), 5'($urandom), rand_word(), rand_word());
        pushed++;
      end else begin
        if ($urandom_range(99) < 80) begin
          recent[$urandom_range(3)] = ($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(31));
          push_req(OP_SET_DEST, recent[$urandom_range(3)], 5'($urandom), $urandom, $urandom);
          pushed++;
        end
        repeat ($urandom_range(2)) begin
          q = ($urandom_range(99) < 65) ? recent[$urandom_range(3)] : 5'($urandom_range(31));
          push_req(OP_QUERY, 5'($urandom), q, $urandom, rand_word());
          pushed++;
        end
        if ($urandom_range(1)) begin
          push_req(OP_POST_EXE, 5'($urandom), 5'($urandom), rand_word(), $urandom);
          pushed++;
        end
        if ($urandom_range(1)) begin
          push_req(OP_POST_MEM, 5'($urandom), 5'($urandom), rand_word(), $urandom);
          pushed++;
        end
        if ($urandom_range(1)) begin
          q = ($urandom_range(99) < 65) ? recent[$urandom_range(3)] : 5'($urandom_range(31));
          push_req(OP_QUERY, 5'($urandom), q, $urandom, rand_word());
          pushed++;
        end
        push_req(OP_ADVANCE, 5'($urandom), 5'($urandom), $urandom, $urandom);
        pushed++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_mode(1'b0);

    // Directed: unfilled posts, x0, file fallback, pending execute, forwarding from memory and writeback
    push_req(OP_POST_EXE, '0, '0, AllOnes, '0);        // execute not yet filled
    push_req(OP_POST_MEM, '0, '0, '0, AllOnes);        // memory not yet filled
    push_req(OP_QUERY, '0, 5'd31, '0, AllOnes);        // empty pipe: file value
    push_req(OP_QUERY, 5'd31, 5'd0, AllOnes, AllOnes); // x0 reads zero
    push_req(OpReserved, 5'd31, 5'd31, AllOnes, AllOnes);
    push_req(OP_ADVANCE, '0, '0, '0, '0);
    push_req(OP_SET_DEST, 5'd31, '0, '0, '0);
    push_req(OP_ADVANCE, '0, '0, '0, '0);
    push_req(OP_QUERY, '0, 5'd31, '0, '0);             // pending execute
    push_req(OP_POST_EXE, '0, '0, AllOnes, '0);
    push_req(OP_QUERY, '0, 5'd31, '0, '0);             // still pending even with a value
    push_req(OP_SET_DEST, 5'd5, '0, '0, '0);
    push_req(OP_ADVANCE, '0, '0, '0, '0);
    push_req(OP_QUERY, '0, 5'd31, '0, '0);             // forward from memory
    push_req(OP_ADVANCE, '0, '0, '0, '0);
    push_req(OP_QUERY, '0, 5'd5, '0, AllOnes);         // memory value missing
    push_req(OP_QUERY, '0, 5'd31, '0, '0);             // forward from writeback
    push_req(OP_POST_MEM, '0, '0, '0, '0);
    push_req(OP_QUERY, '0, 5'd5, '0, AllOnes);
    write_mode(1'b1);
    push_req(OP_QUERY, '0, 5'd16, '0, AllOnes);        // out of range in RV32E
    push_req(OP_QUERY, '0, 5'd15, '0, AllOnes);
    push_req(OP_SET_DEST, 5'd9, '0, '0, '0);
    repeat (3) push_req(OP_ADVANCE, '0, '0, '0, '0);
    push_req(OP_QUERY, '0, 5'd9, '0, AllOnes);         // writeback value missing

    // Sink holds off while the source streams without gaps
    wait_drained();
    src_idle_pct = 0;
    hold_off_req = 1'b1;
    queue_program(150);
    wait_drained();
    src_idle_pct = 37;

    write_mode(1'b0);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    queue_program(150);
    wait_drained();
    src_idle_pct = 37;
    sink_idle_pct = 37;
    queue_program(200);

    write_mode(1'b1);
    queue_program(150);
    wait_drained();
    repeat (5) @(negedge clk_i);

    if (errors == 0 && answer_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> pipeline_forwarding_hazard_unit.f
src/pfhu_pkg.sv
src/pfhu_cell.sv
src/pipeline_forwarding_hazard_unit.sv
sim/tb.sv
